>>> hw/rtl/ws_pkg.sv
package ws_pkg;

  localparam int PORT_COUNT  = 16;
  localparam int PORT_W      = 4;
  localparam int COUNT_WIDTH = 12;
  localparam int COLOR_W     = 8;
  localparam int SHIFT_W     = 3 * COLOR_W;
  localparam int BITS_W      = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [BITS_W-1:0] BITS_PER_PIXEL = BITS_W'(SHIFT_W);

  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_LOW  = 3'd4;

  localparam logic [COUNT_WIDTH-1:0] ONE_HIGH_RST  = COUNT_WIDTH'(40);
  localparam logic [COUNT_WIDTH-1:0] ONE_LOW_RST   = COUNT_WIDTH'(23);
  localparam logic [COUNT_WIDTH-1:0] ZERO_HIGH_RST = COUNT_WIDTH'(20);
  localparam logic [COUNT_WIDTH-1:0] ZERO_LOW_RST  = COUNT_WIDTH'(43);
  localparam logic [COUNT_WIDTH-1:0] LEAD_LOW_RST  = COUNT_WIDTH'(10);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEAD = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } phase_t;

  typedef struct packed {
    logic                   offer;
    logic [PORT_W-1:0]      port;
    logic [SHIFT_W-1:0]     pixel;
  } tick_t;

  typedef struct packed {
    logic  valid;
    tick_t tick;
  } q_head_t;

  typedef struct packed {
    logic                   wr;
    logic [CFG_IDX_W-1:0]   index;
    logic [COUNT_WIDTH-1:0] data;
  } cfg_wr_t;

  function automatic logic [COUNT_WIDTH-1:0] at_least_one(input logic [COUNT_WIDTH-1:0] v);
    at_least_one = (v == '0) ? COUNT_WIDTH'(1) : v;
  endfunction

endpackage

>>> hw/rtl/ws2811_pixel_waveform_driver.sv
// channel  direction  handshake           payload
// in_      input      in_valid/in_stall   pixel_valid, port, green, red, blue
// out_     output     out_valid/out_stall pins, ready_res, dropped
// cfg_     input      cfg_valid/cfg_ready index, data (5 timing registers)
//
// one input beat per cycle sustained while the output is not stalled: each beat is
// one waveform tick, stepped once by the engine; a result passes from its beat
// through the queue and the engine into the output register
// a two-beat queue parts the input from the engine, an output register holds
// the result; a stalled output holds the engine and fills the queue
// synchronous active-low reset; timing registers return to their defaults
module ws2811_pixel_waveform_driver
  import ws_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_pixel_valid,
  input  logic [PORT_W-1:0]      in_port,
  input  logic [COLOR_W-1:0]     in_green,
  input  logic [COLOR_W-1:0]     in_red,
  input  logic [COLOR_W-1:0]     in_blue,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PORT_COUNT-1:0]  out_pins,
  output logic                   out_ready_res,
  output logic                   out_dropped,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COUNT_WIDTH-1:0] cfg_data
);

  q_head_t head;
  logic    pop;
  cfg_wr_t cfg;

  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  ws_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_valid (in_pixel_valid),
    .in_port        (in_port),
    .in_green       (in_green),
    .in_red         (in_red),
    .in_blue        (in_blue),
    .head           (head),
    .pop            (pop)
  );

  ws_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pins      (out_pins),
    .out_ready_res (out_ready_res),
    .out_dropped   (out_dropped)
  );

endmodule

>>> hw/rtl/ws_front.sv
module ws_front
  import ws_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_pixel_valid,
  input  logic [PORT_W-1:0]  in_port,
  input  logic [COLOR_W-1:0] in_green,
  input  logic [COLOR_W-1:0] in_red,
  input  logic [COLOR_W-1:0] in_blue,
  output q_head_t            head,
  input  logic               pop
);

  tick_t               q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  count_r;
  logic [Q_CNT_W-1:0]  count_nxt;
  logic                push;
  logic                do_pop;
  tick_t               beat;

  assign in_stall = (count_r == Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count_r != '0);

  // classify the beat: only offered pixels carry meaning in the payload
  always_comb begin
    beat.offer = in_pixel_valid;
    beat.port  = in_port;
    beat.pixel = {in_green, in_red, in_blue};
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= beat;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.tick  = q_mem[rd_ptr_r];

endmodule

>>> hw/rtl/ws_engine.sv
module ws_engine
  import ws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_wr_t               cfg,
  input  q_head_t               head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PORT_COUNT-1:0] out_pins,
  output logic                  out_ready_res,
  output logic                  out_dropped
);

  logic [COUNT_WIDTH-1:0] one_high_r, one_low_r, zero_high_r, zero_low_r, lead_low_r;

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] tick_count_r, tick_count_nxt;
  logic [SHIFT_W-1:0]     shift_r, shift_nxt;
  logic [BITS_W-1:0]      bits_left_r, bits_left_nxt;
  logic [PORT_W-1:0]      port_r, port_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [PORT_COUNT-1:0]  out_pins_r;
  logic                   out_ready_r;
  logic                   out_dropped_r;

  logic                   advance;
  logic [COUNT_WIDTH-1:0] tc_dec;
  logic [SHIFT_W-1:0]     shifted;
  logic [PORT_COUNT-1:0]  res_pins;
  logic                   res_ready;
  logic                   res_dropped;

  assign advance = head.valid && (!out_valid_r || !out_stall);
  assign pop     = advance;
  assign tc_dec  = (tick_count_r == '0) ? '0 : tick_count_r - COUNT_WIDTH'(1);
  assign shifted = {shift_r[SHIFT_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_high_r  <= ONE_HIGH_RST;
      one_low_r   <= ONE_LOW_RST;
      zero_high_r <= ZERO_HIGH_RST;
      zero_low_r  <= ZERO_LOW_RST;
      lead_low_r  <= LEAD_LOW_RST;
    end else if (cfg.wr) begin
      unique case (cfg.index)
        CFG_ONE_HIGH:  one_high_r  <= cfg.data;
        CFG_ONE_LOW:   one_low_r   <= cfg.data;
        CFG_ZERO_HIGH: zero_high_r <= cfg.data;
        CFG_ZERO_LOW:  zero_low_r  <= cfg.data;
        CFG_LEAD_LOW:  lead_low_r  <= cfg.data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    shift_nxt      = shift_r;
    bits_left_nxt  = bits_left_r;
    port_nxt       = port_r;
    if (advance) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (head.tick.offer) begin
            shift_nxt     = head.tick.pixel;
            bits_left_nxt = BITS_PER_PIXEL;
            port_nxt      = head.tick.port;
            if (lead_low_r != '0) begin
              phase_nxt      = PH_LEAD;
              tick_count_nxt = lead_low_r;
            end else begin
              phase_nxt      = PH_HIGH;
              tick_count_nxt = at_least_one(head.tick.pixel[SHIFT_W-1] ? one_high_r
                                                                       : zero_high_r);
            end
          end
        end
        PH_LEAD: begin
          tick_count_nxt = tc_dec;
          if (tc_dec == '0) begin
            phase_nxt      = PH_HIGH;
            tick_count_nxt = at_least_one(shift_r[SHIFT_W-1] ? one_high_r : zero_high_r);
          end
        end
        PH_HIGH: begin
          tick_count_nxt = tc_dec;
          if (tc_dec == '0) begin
            phase_nxt      = PH_LOW;
            tick_count_nxt = at_least_one(shift_r[SHIFT_W-1] ? one_low_r : zero_low_r);
          end
        end
        PH_LOW: begin
          tick_count_nxt = tc_dec;
          if (tc_dec == '0) begin
            shift_nxt     = shifted;
            bits_left_nxt = bits_left_r - BITS_W'(1);
            if (bits_left_r == BITS_W'(1)) begin
              phase_nxt      = PH_IDLE;
              tick_count_nxt = '0;
            end else begin
              phase_nxt      = PH_HIGH;
              tick_count_nxt = at_least_one(shifted[SHIFT_W-1] ? one_high_r : zero_high_r);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // per-tick result
  always_comb begin
    res_pins    = '0;
    res_ready   = (phase_r == PH_IDLE);
    res_dropped = (phase_r != PH_IDLE) && head.tick.offer;
    if ((phase_r == PH_HIGH) && ({1'b0, port_r} < (PORT_W + 1)'(PORT_COUNT))) begin
      res_pins = PORT_COUNT'(1) << port_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      shift_r      <= '0;
      bits_left_r  <= '0;
      port_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      shift_r      <= shift_nxt;
      bits_left_r  <= bits_left_nxt;
      port_r       <= port_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pins_r    <= res_pins;
      out_ready_r   <= res_ready;
      out_dropped_r <= res_dropped;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pins      = out_pins_r;
  assign out_ready_res = out_ready_r;
  assign out_dropped   = out_dropped_r;

endmodule

>>> hw/rtl/ws_checker.sv
module ws_checker
  import ws_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [PORT_COUNT-1:0]  out_pins,
  input logic                   out_ready_res,
  input logic                   out_dropped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pins) && $stable(out_ready_res)
                               && $stable(out_dropped))
    else $error("stalled output beat changed");

  a_one_pin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_pins))
    else $error("more than one pin high");

  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready_res |-> out_pins == '0)
    else $error("pin high while idle");

  a_idle_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready_res |-> !out_dropped)
    else $error("drop reported while idle");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty right after reset");

endmodule

bind ws2811_pixel_waveform_driver ws_checker u_ws_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pins      (out_pins),
  .out_ready_res (out_ready_res),
  .out_dropped   (out_dropped)
);

>>> test/tb.sv
module tb
  import ws_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HANG_LIMIT = 1000;

  typedef struct {
    logic [PORT_COUNT-1:0] pins;
    logic                  ready;
    logic                  dropped;
  } pin_sample_t;

  class pixel_wave_scoreboard;
    logic [COUNT_WIDTH-1:0] timing [0:CFG_LEAD_LOW];
    logic [SHIFT_W-1:0]     shift_bits;
    logic [BITS_W-1:0]      bits_left;
    phase_t                 phase;
    logic [COUNT_WIDTH-1:0] tick_count;
    logic [PORT_W-1:0]      active_port;
    pin_sample_t            expected_ticks [$];
    int                     mismatches;
    int                     checked;

    function new();
      timing[CFG_ONE_HIGH]  = ONE_HIGH_RST;
      timing[CFG_ONE_LOW]   = ONE_LOW_RST;
      timing[CFG_ZERO_HIGH] = ZERO_HIGH_RST;
      timing[CFG_ZERO_LOW]  = ZERO_LOW_RST;
      timing[CFG_LEAD_LOW]  = LEAD_LOW_RST;
      shift_bits  = '0;
      bits_left   = '0;
      phase       = PH_IDLE;
      tick_count  = '0;
      active_port = '0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function logic [COUNT_WIDTH-1:0] min_one(logic [COUNT_WIDTH-1:0] v);
      return (v == '0) ? COUNT_WIDTH'(1) : v;
    endfunction

    function void load_high();
      phase = PH_HIGH;
      tick_count = min_one(shift_bits[SHIFT_W-1] ? timing[CFG_ONE_HIGH] : timing[CFG_ZERO_HIGH]);
    endfunction

    function void load_low();
      phase = PH_LOW;
      tick_count = min_one(shift_bits[SHIFT_W-1] ? timing[CFG_ONE_LOW] : timing[CFG_ZERO_LOW]);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_WIDTH-1:0] value);
      if (idx <= CFG_LEAD_LOW) begin
        timing[idx] = value;
      end
    endfunction

    function bit is_idle();
      return phase == PH_IDLE;
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    function void note_tick(logic pv, logic [PORT_W-1:0] port,
                            logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] r,
                            logic [COLOR_W-1:0] b);
      pin_sample_t s;
      s.pins    = '0;
      s.ready   = 1'b0;
      s.dropped = 1'b0;
      if (phase == PH_IDLE) begin
        s.ready = 1'b1;
        if (pv) begin
          shift_bits  = {g, r, b};
          bits_left   = BITS_PER_PIXEL;
          active_port = port;
          if (timing[CFG_LEAD_LOW] != '0) begin
            phase      = PH_LEAD;
            tick_count = timing[CFG_LEAD_LOW];
          end else begin
            load_high();
          end
        end
      end else begin
        if (pv) begin
          s.dropped = 1'b1;
        end
        if (phase == PH_HIGH && int'(active_port) < PORT_COUNT) begin
          s.pins[active_port] = 1'b1;
        end
        tick_count = min_one(tick_count) - COUNT_WIDTH'(1);
        if (tick_count == '0) begin
          case (phase)
            PH_LEAD: begin
              load_high();
            end
            PH_HIGH: begin
              load_low();
            end
            default: begin
              shift_bits = shift_bits << 1;
              bits_left  = bits_left - BITS_W'(1);
              if (bits_left == '0) begin
                phase      = PH_IDLE;
                tick_count = '0;
              end else begin
                load_high();
              end
            end
          endcase
        end
      end
      expected_ticks.push_back(s);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void check_result(logic [PORT_COUNT-1:0] pins, logic ready, logic dropped);
      pin_sample_t want;
      checked++;
      if (expected_ticks.size() == 0) begin
        report($sformatf("result %0d arrived with no tick waiting", checked));
        return;
      end
      want = expected_ticks.pop_front();
      if (pins !== want.pins || ready !== want.ready || dropped !== want.dropped) begin
        report($sformatf("result %0d: pins exp %h got %h, ready exp %b got %b, dropped exp %b got %b",
                         checked, want.pins, pins, want.ready, ready, want.dropped, dropped));
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_pixel_valid;
  logic [PORT_W-1:0]      in_port;
  logic [COLOR_W-1:0]     in_green;
  logic [COLOR_W-1:0]     in_red;
  logic [COLOR_W-1:0]     in_blue;
  logic                   out_valid;
  logic                   out_stall;
  logic [PORT_COUNT-1:0]  out_pins;
  logic                   out_ready_res;
  logic                   out_dropped;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [COUNT_WIDTH-1:0] cfg_data;

  pixel_wave_scoreboard sb;
  int calm_left = 0;
  int quiet_cycles = 0;

  ws2811_pixel_waveform_driver u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_valid (in_pixel_valid),
    .in_port        (in_port),
    .in_green       (in_green),
    .in_red         (in_red),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pins       (out_pins),
    .out_ready_res  (out_ready_res),
    .out_dropped    (out_dropped),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side back-pressure
  initial begin
    int free_len;
    int stall_len;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      free_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      out_stall <= 1'b0;
      repeat (free_len) @(negedge clk);
      out_stall <= 1'b1;
      repeat (stall_len) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_pins, out_ready_res, out_dropped);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic drive_tick(input logic pv, input logic [PORT_W-1:0] port,
                            input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r,
                            input logic [COLOR_W-1:0] b);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if (pick < 2) begin
      calm_left = $urandom_range(20, 80);
      gap = 0;
    end else if (pick < 55) begin
      gap = 0;
    end else if (pick < 93) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_valid <= pv;
    in_port        <= port;
    in_green       <= g;
    in_red         <= r;
    in_blue        <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(pv, port, g, r, b);
  endtask

  // mostly quiet ticks, now and then a pixel offered while busy
  task automatic drive_filler();
    drive_tick($urandom_range(0, 15) == 0, PORT_W'($urandom), COLOR_W'($urandom),
               COLOR_W'($urandom), COLOR_W'($urandom));
  endtask

  task automatic send_pixel(input logic [PORT_W-1:0] port, input logic [COLOR_W-1:0] g,
                            input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] b);
    while (!sb.is_idle()) drive_filler();
    drive_tick(1'b1, port, g, r, b);
  endtask

  task automatic finish_pixel();
    while (!sb.is_idle()) drive_filler();
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic program_timing(input logic [CFG_IDX_W-1:0] idx,
                                input logic [COUNT_WIDTH-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [COUNT_WIDTH-1:0] one_high,
                            input logic [COUNT_WIDTH-1:0] one_low,
                            input logic [COUNT_WIDTH-1:0] zero_high,
                            input logic [COUNT_WIDTH-1:0] zero_low,
                            input logic [COUNT_WIDTH-1:0] lead_low);
    drain();
    program_timing(CFG_ONE_HIGH, one_high);
    program_timing(CFG_ONE_LOW, one_low);
    program_timing(CFG_ZERO_HIGH, zero_high);
    program_timing(CFG_ZERO_LOW, zero_low);
    program_timing(CFG_LEAD_LOW, lead_low);
    cfg_done();
  endtask

  initial begin
    logic pv;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_valid = 1'b0;
    in_port        = '0;
    in_green       = '0;
    in_red         = '0;
    in_blue        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset timing for the lead-in and the first bits
    send_pixel(4'd1, 8'h92, 8'h34, 8'h56);
    repeat (140) drive_filler();

    // short bits take over mid-pixel, no lead-in, back-to-back pixels
    set_timing(12'd2, 12'd1, 12'd1, 12'd2, 12'd0);
    finish_pixel();
    send_pixel(4'd15, 8'hFF, 8'h00, 8'hA5);
    finish_pixel();

    // zero durations count as one tick
    set_timing(12'd0, 12'd0, 12'd0, 12'd0, 12'd2);
    send_pixel(4'd3, 8'hA5, 8'h5A, 8'hC3);
    finish_pixel();

    // random timing, phases end mid-pixel
    for (int p = 0; p < 3; p++) begin
      drain();
      for (int i = 0; i <= int'(CFG_LEAD_LOW); i++) begin
        if ($urandom_range(0, 3) != 0) begin
          program_timing(CFG_IDX_W'(i), ($urandom_range(0, 15) == 0) ?
                         COUNT_WIDTH'($urandom_range(5, 30)) :
                         COUNT_WIDTH'($urandom_range(0, 4)));
        end
      end
      if (p == 0 || $urandom_range(0, 2) == 0) begin
        program_timing(CFG_IDX_W'($urandom_range(int'(CFG_LEAD_LOW) + 1,
                                                 (1 << CFG_IDX_W) - 1)),
                       COUNT_WIDTH'($urandom));
      end
      cfg_done();
      repeat (60) begin
        pv = sb.is_idle() ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
        drive_tick(pv, PORT_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                   COLOR_W'($urandom));
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
